/* hdl/lfws_pkg.sv */
package lfws_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    // action codes
    typedef enum logic [1:0] {
        ACT_SEND   = 2'd0,
        ACT_CURSOR = 2'd1,
        ACT_LIGHT  = 2'd2,
        ACT_INIT   = 2'd3
    } action_t;

    // port codes
    localparam logic [2:0] PORT_DATA  = 3'd0;
    localparam logic [2:0] PORT_CTRL  = 3'd1;
    localparam logic [2:0] PORT_LIGHT = 3'd2;
    localparam logic [2:0] PORT_DDIR  = 3'd3;
    localparam logic [2:0] PORT_CDIR  = 3'd4;

    localparam logic [7:0] CTL_RS      = 8'h01;
    localparam logic [7:0] CTL_E       = 8'h04;
    localparam int         FLAG_DATA   = 1;
    localparam int         FLAG_NIBBLE = 0;

    localparam logic [2:0] ROW_MAX   = 3'd3;
    localparam logic [4:0] COL_MAX   = 5'd19;
    localparam logic [7:0] LIGHT_MAX = 8'd100;
    // floor(x / 100) == (x * 5243) >> 19 for x <= 25500
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int          RECIP_SH  = 19;

    localparam logic [5:0] INIT_LIGHT_STEP = 6'd52;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] value;
        logic [1:0] send_flags;
        logic [2:0] row;
        logic [4:0] col;
    } req_t;

    typedef struct packed {
        logic [2:0] port;
        logic [7:0] byte_res;
        logic       last;
    } res_t;

    typedef enum logic [1:0] {
        KIND_SEND,
        KIND_LIGHT,
        KIND_INIT
    } kind_t;

    // classified request, one queue entry
    typedef struct packed {
        kind_t      kind;
        logic [7:0] cmd;
        logic       rs;
        logic       nib_only;
        logic [7:0] light;
    } desc_t;

    typedef struct packed {
        logic [2:0] port;
        logic [7:0] data;
    } wr_t;

    function automatic logic [7:0] row_base(input logic [1:0] r);
        logic [7:0] b;
        case (r)
            2'd0:    b = 8'h00;
            2'd1:    b = 8'h40;
            2'd2:    b = 8'h14;
            default: b = 8'h54;
        endcase
        return b;
    endfunction

    // sub[2] selects the low nibble, sub[1:0] the phase within one nibble
    function automatic wr_t send_write(input logic [7:0] b, input logic rs,
                                       input logic [2:0] sub);
        wr_t        w;
        logic [3:0] nib;
        logic [7:0] rsb;
        nib = sub[2] ? b[3:0] : b[7:4];
        rsb = rs ? CTL_RS : 8'h00;
        case (sub[1:0])
            2'd0:    w = '{port: PORT_DATA, data: {nib, 4'h0}};
            2'd2:    w = '{port: PORT_CTRL, data: rsb | CTL_E};
            default: w = '{port: PORT_CTRL, data: rsb};
        endcase
        return w;
    endfunction

    // power-up writes, steps 0..51 (the backlight write follows)
    function automatic wr_t init_write(input logic [5:0] step);
        wr_t        w;
        logic [5:0] j;
        logic [7:0] c;
        j = 6'd0;
        c = 8'h00;
        if (step < 6'd4) begin
            case (step[1:0])
                2'd0:    w = '{port: PORT_DATA, data: 8'h00};
                2'd1:    w = '{port: PORT_CTRL, data: 8'h00};
                2'd2:    w = '{port: PORT_DDIR, data: 8'hFF};
                default: w = '{port: PORT_CDIR, data: 8'h07};
            endcase
        end else if (step < 6'd20) begin
            j = step - 6'd4;
            c = (j[3:2] == 2'd3) ? 8'h20 : 8'h30;
            w = send_write(c, 1'b0, {1'b0, j[1:0]});
        end else begin
            j = step - 6'd20;
            case (j[4:3])
                2'd0:    c = 8'h28;
                2'd1:    c = 8'h0C;
                2'd2:    c = 8'h01;
                default: c = 8'h06;
            endcase
            w = send_write(c, 1'b0, j[2:0]);
        end
        return w;
    endfunction

endpackage

/* hdl/lfws_front.sv */
module lfws_front (
    input  lfws_pkg::req_t  req,
    output lfws_pkg::desc_t desc
);
    import lfws_pkg::*;

    logic [2:0]  row_c;
    logic [4:0]  col_c;
    logic [7:0]  lv;
    logic [14:0] lx;
    logic [27:0] lp;

    always_comb
    begin
        row_c = (req.row > ROW_MAX) ? ROW_MAX : req.row;
        col_c = (req.col > COL_MAX) ? COL_MAX : req.col;
        lv    = (req.value > LIGHT_MAX) ? LIGHT_MAX : req.value;
        lx    = {lv[6:0], 8'h00} - {8'h00, lv[6:0]};  // lv * 255
        lp    = {13'h0, lx} * {15'h0, RECIP_100};
        desc.light    = lp[RECIP_SH+7:RECIP_SH];
        desc.kind     = KIND_SEND;
        desc.cmd      = req.value;
        desc.rs       = req.send_flags[FLAG_DATA];
        desc.nib_only = req.send_flags[FLAG_NIBBLE];
        case (action_t'(req.action))
            ACT_SEND:
            begin
                desc.kind = KIND_SEND;
            end
            ACT_CURSOR:
            begin
                desc.kind     = KIND_SEND;
                desc.cmd      = 8'h80 | (row_base(row_c[1:0]) + {3'h0, col_c});
                desc.rs       = 1'b0;
                desc.nib_only = 1'b0;
            end
            ACT_LIGHT:
            begin
                desc.kind = KIND_LIGHT;
            end
            default:
            begin
                desc.kind = KIND_INIT;
            end
        endcase
    end

endmodule

/* hdl/lfws_queue.sv */
module lfws_queue #(
    parameter int DEPTH = lfws_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lfws_pkg::desc_t din,
    input  logic            pop,
    output lfws_pkg::desc_t head,
    output logic            head_valid,
    output logic            full
);
    import lfws_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    desc_t         mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* hdl/lfws_back.sv */
module lfws_back (
    input  logic            clk,
    input  logic            rst_n,
    input  lfws_pkg::desc_t head,
    input  logic            head_valid,
    output logic            pop,
    output lfws_pkg::res_t  res,
    output logic            strobe
);
    import lfws_pkg::*;

    logic [5:0] step_reg, step_next;
    res_t       res_reg, res_next;
    logic       strobe_reg;
    wr_t        w;
    logic       last;

    always_comb
    begin
        w    = send_write(head.cmd, head.rs, step_reg[2:0]);
        last = 1'b0;
        case (head.kind)
            KIND_SEND:
            begin
                last = head.nib_only ? (step_reg[1:0] == 2'd3)
                                     : (step_reg[2:0] == 3'd7);
            end
            KIND_LIGHT:
            begin
                w    = '{port: PORT_LIGHT, data: head.light};
                last = 1'b1;
            end
            default:
            begin
                if (step_reg == INIT_LIGHT_STEP)
                begin
                    w    = '{port: PORT_LIGHT, data: head.light};
                    last = 1'b1;
                end
                else
                begin
                    w = init_write(step_reg);
                end
            end
        endcase
        res_next  = '{port: w.port, byte_res: w.data, last: last};
        pop       = head_valid && last;
        step_next = pop ? '0 : (head_valid ? step_reg + 6'd1 : step_reg);
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            step_reg   <= step_next;
            strobe_reg <= head_valid;
        end
    end

    assign res    = res_reg;
    assign strobe = strobe_reg;

endmodule

/* hdl/lcd_four_bit_write_sequencer_top.sv */
// Four-bit character LCD write sequencer. A request is taken on a clock edge
// with start high and busy low; it then comes out as a run of port writes,
// one per cycle on res with strobe high, the final one flagged by res.last.
// The receiver cannot stall, so writes leave as soon as they are made. A
// byte send or cursor move gives 8 writes, a nibble-only send 4, a backlight
// set 1 and display init 53. A request's writes are contiguous, and queued
// requests follow each other with no idle cycle. When the queue is empty the
// first write passes the queue's count register and then the res register
// before it appears on res. busy is high only while the request queue
// (QUEUE_DEPTH entries) is full.
module lcd_four_bit_write_sequencer_top #(
    parameter int QUEUE_DEPTH = lfws_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  lfws_pkg::req_t req,
    output lfws_pkg::res_t res,
    output logic           strobe
);
    import lfws_pkg::*;

    desc_t desc;      // classified request from the front end
    desc_t head;      // request the back end is working on
    logic  head_valid;
    logic  pop;
    logic  full;

    // front end: clamp cursor, build command byte, scale backlight level
    lfws_front u_front (
        .req  (req),
        .desc (desc)
    );

    // short queue lets accepts run ahead of the write sequencer
    lfws_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (start),
        .din        (desc),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (full)
    );

    // back end: steps through the writes of the head request
    lfws_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .res        (res),
        .strobe     (strobe)
    );

    assign busy = full;

endmodule

/* hdl/lfws_checker.sv */
module lfws_checker (
    input logic           clk,
    input logic           rst_n,
    input lfws_pkg::res_t res,
    input logic           strobe
);
    import lfws_pkg::*;

    // writes of one request come out without a gap
    a_contig: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !res.last |=> strobe)
        else $error("gap inside a request");

    a_port: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (res.port <= PORT_CDIR))
        else $error("bad port code");

    // backlight write always ends its request
    a_light: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && res.port == PORT_LIGHT |-> res.last)
        else $error("backlight write not last");

    // E pulse lasts one beat and drops on the control port
    a_epulse: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && res.port == PORT_CTRL && res.byte_res[2]
        |=> strobe && res.port == PORT_CTRL && !res.byte_res[2])
        else $error("E pulse not closed");

    a_dir: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && res.port == PORT_DDIR
        |=> strobe && res.port == PORT_CDIR && res.byte_res == 8'h07)
        else $error("control direction write missing");

endmodule

bind lcd_four_bit_write_sequencer_top lfws_checker u_lfws_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .res    (res),
    .strobe (strobe)
);
